@@ hdl/trs_mb_pkg.sv @@
// Shared constants, types and arithmetic helpers of the TRS matrix builder.
package trs_mb_pkg;

  localparam int ANGLE_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF  = 16;

  localparam int POS_W  = 32;
  localparam int ANG_W  = 16;
  localparam int SCL_W  = 24;
  localparam int MAT_W  = 32;
  localparam int ROT_W  = 34;
  localparam int TRIG_W = 31;
  localparam int AXES   = 3;
  localparam int MAT_N  = 12;

  localparam int SINQ_LAT = 24;
  localparam int DIV_Q_W  = 33;
  localparam int DIV_LAT  = DIV_Q_W + 2;

  localparam logic [TRIG_W-1:0] HALF_PI_Q30 = 31'd1686629713;
  localparam logic [TRIG_W-1:0] TRIG_ONE    = 31'd1073741824;

  localparam logic signed [MAT_W-1:0] MAT_MAX = 32'sh7FFFFFFF;
  localparam logic signed [MAT_W-1:0] MAT_MIN = 32'sh80000000;

  localparam logic [7:0] TAY_DIV [1:7] = '{8'd6, 8'd20, 8'd42, 8'd72, 8'd110, 8'd156, 8'd210};
  localparam logic [32:0] TAY_RECIP [1:7] = '{
    33'd5726623061, 33'd1717986918, 33'd818089008, 33'd477218588,
    33'd312361257, 33'd220254733, 33'd163617801
  };

  localparam logic ACT_FWD = 1'b0;
  localparam logic ACT_INV = 1'b1;

  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

  typedef struct packed {
    logic                         action;
    logic [AXES-1:0][POS_W-1:0]   pos;
    logic [AXES-1:0][SCL_W-1:0]   scale;
    logic [AXES-1:0][1:0]         quad;
  } meta_t;

  function automatic logic signed [ROT_W-1:0] rmul30(input logic signed [ROT_W-1:0] a,
                                                     input logic signed [ROT_W-1:0] b);
    logic [ROT_W-1:0]   ma;
    logic [ROT_W-1:0]   mb;
    logic [2*ROT_W-1:0] p;
    logic [ROT_W-1:0]   m;
    ma = a[ROT_W-1] ? ROT_W'(-a) : ROT_W'(a);
    mb = b[ROT_W-1] ? ROT_W'(-b) : ROT_W'(b);
    p  = (2*ROT_W)'(ma) * (2*ROT_W)'(mb);
    p  = (p + ((2*ROT_W)'(1) << 29)) >> 30;
    m  = p[ROT_W-1:0];
    return (a[ROT_W-1] != b[ROT_W-1]) ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic signed [MAT_W-1:0] sat32(input logic signed [63:0] v);
    logic signed [MAT_W-1:0] r;
    if (v > 64'sd2147483647) begin
      r = MAT_MAX;
    end else if (v < -64'sd2147483648) begin
      r = MAT_MIN;
    end else begin
      r = v[MAT_W-1:0];
    end
    return r;
  endfunction

endpackage

@@ hdl/trs_mb_if.sv @@
// Input and result channels of the TRS matrix builder.
interface trs_mb_in_if;
  import trs_mb_pkg::*;
  logic                     valid;
  logic                     ready;
  logic                     action;
  logic signed [POS_W-1:0]  pos_x;
  logic signed [POS_W-1:0]  pos_y;
  logic signed [POS_W-1:0]  pos_z;
  logic [ANG_W-1:0]         angle_x;
  logic [ANG_W-1:0]         angle_y;
  logic [ANG_W-1:0]         angle_z;
  logic [SCL_W-1:0]         scale_x;
  logic [SCL_W-1:0]         scale_y;
  logic [SCL_W-1:0]         scale_z;
  modport source (output valid, action, pos_x, pos_y, pos_z, angle_x, angle_y, angle_z,
                  scale_x, scale_y, scale_z, input ready);
  modport sink (input valid, action, pos_x, pos_y, pos_z, angle_x, angle_y, angle_z,
                scale_x, scale_y, scale_z, output ready);
endinterface

interface trs_mb_out_if;
  import trs_mb_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [MAT_W-1:0]  m_r0c0;
  logic signed [MAT_W-1:0]  m_r0c1;
  logic signed [MAT_W-1:0]  m_r0c2;
  logic signed [MAT_W-1:0]  m_r0c3;
  logic signed [MAT_W-1:0]  m_r1c0;
  logic signed [MAT_W-1:0]  m_r1c1;
  logic signed [MAT_W-1:0]  m_r1c2;
  logic signed [MAT_W-1:0]  m_r1c3;
  logic signed [MAT_W-1:0]  m_r2c0;
  logic signed [MAT_W-1:0]  m_r2c1;
  logic signed [MAT_W-1:0]  m_r2c2;
  logic signed [MAT_W-1:0]  m_r2c3;
  modport source (output valid, m_r0c0, m_r0c1, m_r0c2, m_r0c3, m_r1c0, m_r1c1, m_r1c2,
                  m_r1c3, m_r2c0, m_r2c1, m_r2c2, m_r2c3, input ready);
  modport sink (input valid, m_r0c0, m_r0c1, m_r0c2, m_r0c3, m_r1c0, m_r1c1, m_r1c2,
                m_r1c3, m_r2c0, m_r2c1, m_r2c2, m_r2c3, output ready);
endinterface

@@ hdl/trs_mb_sinq.sv @@
// Pipelined quarter-wave sine: Taylor series to the x^15 term, three stages per term.
module trs_mb_sinq #(
  parameter int ANGLE_BITS = trs_mb_pkg::ANGLE_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            en_i,
  input  logic [ANGLE_BITS-2:0]           r_i,
  output logic [trs_mb_pkg::TRIG_W-1:0]   s_o
);
  import trs_mb_pkg::*;

  localparam int PW = ANGLE_BITS - 1 + TRIG_W;

  logic [PW-1:0]     xp;
  logic [TRIG_W-1:0] x_q;
  logic [61:0]       sq;

  logic [30:0] term_q [8];
  logic [31:0] x2_q   [8];
  logic [33:0] pl_q   [8];
  logic [33:0] mi_q   [8];

  logic [62:0] pa_q  [1:7];
  logic [31:0] xa_q  [1:7];
  logic [33:0] pla_q [1:7];
  logic [33:0] mia_q [1:7];

  logic [32:0] vb_q  [1:7];
  logic [65:0] rq_q  [1:7];
  logic [31:0] xb_q  [1:7];
  logic [33:0] plb_q [1:7];
  logic [33:0] mib_q [1:7];

  logic [TRIG_W-1:0] s_q;
  logic [TRIG_W-1:0] s_d;
  logic [33:0]       diff;

  assign xp = PW'(r_i) * PW'(HALF_PI_Q30);
  assign sq = 62'(x_q) * 62'(x_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q       <= TRIG_W'(xp >> (ANGLE_BITS - 2));
      term_q[0] <= x_q;
      x2_q[0]   <= sq[61:30];
      pl_q[0]   <= 34'(x_q);
      mi_q[0]   <= '0;
    end
  end

  for (genvar k = 1; k <= 7; k++) begin : g_term
    logic [30:0] q0;
    logic [33:0] rem;
    logic [30:0] qk;

    assign q0  = rq_q[k][65:35];
    assign rem = 34'(vb_q[k]) - 34'(q0) * 34'(TAY_DIV[k]);
    assign qk  = (rem >= 34'(TAY_DIV[k])) ? q0 + 31'd1 : q0;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        pa_q[k]   <= 63'(term_q[k-1]) * 63'(x2_q[k-1]);
        xa_q[k]   <= x2_q[k-1];
        pla_q[k]  <= pl_q[k-1];
        mia_q[k]  <= mi_q[k-1];
        vb_q[k]   <= pa_q[k][62:30];
        rq_q[k]   <= 66'(pa_q[k][62:30]) * 66'(TAY_RECIP[k]);
        xb_q[k]   <= xa_q[k];
        plb_q[k]  <= pla_q[k];
        mib_q[k]  <= mia_q[k];
        term_q[k] <= qk;
        x2_q[k]   <= xb_q[k];
        if ((k & 1) == 1) begin
          pl_q[k] <= plb_q[k];
          mi_q[k] <= mib_q[k] + 34'(qk);
        end else begin
          pl_q[k] <= plb_q[k] + 34'(qk);
          mi_q[k] <= mib_q[k];
        end
      end
    end
  end

  assign diff = pl_q[7] - mi_q[7];

  always_comb begin
    if (mi_q[7] >= pl_q[7]) begin
      s_d = '0;
    end else if (diff > 34'(TRIG_ONE)) begin
      s_d = TRIG_ONE;
    end else begin
      s_d = diff[TRIG_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s_q <= s_d;
    end
  end

  assign s_o = s_q;

endmodule

@@ hdl/trs_mb_div.sv @@
// Pipelined restoring divider for inverse-scale entries, one quotient bit per stage.
module trs_mb_div #(
  parameter int FRAC_BITS = trs_mb_pkg::FRAC_BITS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  en_i,
  input  logic signed [trs_mb_pkg::ROT_W-1:0]   num_i,
  input  logic [trs_mb_pkg::SCL_W-1:0]          scale_i,
  output logic signed [trs_mb_pkg::MAT_W-1:0]   q_o
);
  import trs_mb_pkg::*;

  localparam int SH_N = (2 * FRAC_BITS >= 30) ? 2 * FRAC_BITS - 30 : 0;
  localparam int SH_D = (2 * FRAC_BITS >= 30) ? 0 : 30 - 2 * FRAC_BITS;
  localparam int DW   = SCL_W + SH_D;
  localparam int NW   = ((ROT_W + SH_N > DW) ? ROT_W + SH_N : DW) + 1;
  localparam int QW   = DIV_Q_W;

  logic             neg;
  logic [ROT_W-1:0] mag;
  logic [DW-1:0]    dd;
  logic [NW-1:0]    nn;
  logic [NW-1:0]    hi;

  logic [DW-1:0] rem_q  [QW+1];
  logic [QW-1:0] nl_q   [QW+1];
  logic [QW-1:0] qb_q   [QW+1];
  logic [DW-1:0] d_q    [QW+1];
  logic          neg_q  [QW+1];
  logic          zero_q [QW+1];
  logic          ovf_q  [QW+1];

  logic signed [63:0]      qs;
  logic signed [MAT_W-1:0] res_d;
  logic signed [MAT_W-1:0] res_q;

  assign neg = num_i[ROT_W-1];
  assign mag = neg ? ROT_W'(-num_i) : ROT_W'(num_i);
  assign dd  = DW'(scale_i) << SH_D;
  assign nn  = (NW'(mag) << SH_N) + NW'(dd >> 1);
  assign hi  = nn >> QW;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= DW'(hi);
      nl_q[0]   <= nn[QW-1:0];
      qb_q[0]   <= '0;
      d_q[0]    <= dd;
      neg_q[0]  <= neg;
      zero_q[0] <= (mag == '0);
      ovf_q[0]  <= (hi >= NW'(dd));
    end
  end

  for (genvar i = 0; i < QW; i++) begin : g_step
    logic [DW:0] t;
    logic [DW:0] df;
    logic        ge;

    assign t  = {rem_q[i], nl_q[i][QW-1]};
    assign df = t - {1'b0, d_q[i]};
    assign ge = (t >= {1'b0, d_q[i]});

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i+1]  <= ge ? df[DW-1:0] : t[DW-1:0];
        nl_q[i+1]   <= nl_q[i] << 1;
        qb_q[i+1]   <= {qb_q[i][QW-2:0], ge};
        d_q[i+1]    <= d_q[i];
        neg_q[i+1]  <= neg_q[i];
        zero_q[i+1] <= zero_q[i];
        ovf_q[i+1]  <= ovf_q[i];
      end
    end
  end

  assign qs = neg_q[QW] ? -$signed(64'(qb_q[QW])) : $signed(64'(qb_q[QW]));

  always_comb begin
    if (zero_q[QW]) begin
      res_d = '0;
    end else if (ovf_q[QW]) begin
      res_d = neg_q[QW] ? MAT_MIN : MAT_MAX;
    end else begin
      res_d = sat32(qs);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= res_d;
    end
  end

  assign q_o = res_q;

endmodule

@@ hdl/trs_matrix_builder_unit.sv @@
// Top level of the TRS matrix builder: trig, rotation, scale and translation pipeline.
//
// Builds the top three rows of a T*Rz*Ry*Rx*S affine matrix (or its inverse when action
// is set) from a Q16.16 position, three turn-fraction angles and a Q8.16 scale. One item
// enters per clock while the output is not stalled; each result passes through the
// pipeline and then an output register. The pipeline holds the 24-stage Taylor sine
// pipeline and the 35-stage restoring divider that forms the inverse scale. A stalled
// output holds the whole pipeline only once its last stage is full.
module trs_matrix_builder_unit #(
  parameter int ANGLE_BITS = trs_mb_pkg::ANGLE_BITS_DEF,
  parameter int FRAC_BITS  = trs_mb_pkg::FRAC_BITS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  trs_mb_in_if.sink     req_i,
  trs_mb_out_if.source  rsp_o
);
  import trs_mb_pkg::*;

  localparam int LS  = SINQ_LAT;
  localparam int LD  = DIV_LAT;
  localparam int L   = LS + LD + 5;
  localparam int AW1 = ANGLE_BITS - 1;
  localparam logic [AW1-1:0] QSTEPS = AW1'(1) << (ANGLE_BITS - 2);

  function automatic logic signed [63:0] rmulf(input logic signed [MAT_W-1:0] a,
                                               input logic signed [MAT_W-1:0] b);
    logic [MAT_W-1:0] ma;
    logic [MAT_W-1:0] mb;
    logic [63:0]      p;
    ma = a[MAT_W-1] ? MAT_W'(-a) : MAT_W'(a);
    mb = b[MAT_W-1] ? MAT_W'(-b) : MAT_W'(b);
    p  = 64'(ma) * 64'(mb);
    p  = (p + (64'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
    return (a[MAT_W-1] != b[MAT_W-1]) ? -$signed(p) : $signed(p);
  endfunction

  logic         en;
  logic         accept;
  logic         load;
  logic [L-1:0] v_q;
  logic         out_valid_q;
  logic         out_valid_d;

  meta_t meta_in;
  meta_t meta_q [L-1];

  logic [ANG_W-1:0]      ang     [AXES];
  logic [ANGLE_BITS-1:0] phase   [AXES];
  logic [AW1-1:0]        rs      [AXES];
  logic [AW1-1:0]        rc      [AXES];
  logic [TRIG_W-1:0]     sin_a   [AXES];
  logic [TRIG_W-1:0]     sin_b   [AXES];
  logic signed [ROT_W-1:0] sv [AXES];
  logic signed [ROT_W-1:0] cv [AXES];

  logic signed [ROT_W-1:0] czsx_q, cxcz_q, sxsy_q, cxsy_q, cxsz_q, sxsz_q;
  logic signed [ROT_W-1:0] r00_q, r10_q, r21_q, r22_q, sy_q, sz_q;
  logic signed [ROT_W-1:0] t01_q, t02_q, t11_q, t12_q;
  logic signed [ROT_W-1:0] cxsz2_q, sxsz2_q, cxcz2_q, czsx2_q;
  logic signed [ROT_W-1:0] r00b_q, r10b_q, r20b_q, r21b_q, r22b_q;
  logic signed [ROT_W-1:0] rot_q [3][3];

  logic signed [MAT_W-1:0] minv   [3][3];
  logic signed [MAT_W-1:0] fwd_d  [3][3];
  logic signed [MAT_W-1:0] fwd_q  [LD+1][3][3];
  logic signed [MAT_W-1:0] minv_q [3][3];
  logic signed [63:0]      tp_q   [3][3];

  logic [MAT_N-1:0][MAT_W-1:0] mat_d;
  logic [MAT_N-1:0][MAT_W-1:0] mat_q;
  logic [MAT_N-1:0][MAT_W-1:0] out_q;

  assign load        = v_q[L-1] && (!out_valid_q || rsp_o.ready);
  assign en          = !v_q[L-1] || load;
  assign accept      = req_i.valid && en;
  assign req_i.ready = en;
  assign out_valid_d = load || (out_valid_q && !rsp_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (en) begin
        v_q <= {v_q[L-2:0], accept};
      end
      out_valid_q <= out_valid_d;
    end
  end

  assign ang[0] = req_i.angle_x;
  assign ang[1] = req_i.angle_y;
  assign ang[2] = req_i.angle_z;

  for (genvar ax = 0; ax < AXES; ax++) begin : g_axis
    if (ANGLE_BITS >= ANG_W) begin : g_wide
      assign phase[ax] = ANGLE_BITS'(ang[ax]) << (ANGLE_BITS - ANG_W);
    end else begin : g_narrow
      assign phase[ax] = ANGLE_BITS'(ang[ax] >> (ANG_W - ANGLE_BITS));
    end
    assign rs[ax] = AW1'(phase[ax][ANGLE_BITS-3:0]);
    assign rc[ax] = QSTEPS - rs[ax];
    assign meta_in.quad[ax] = phase[ax][ANGLE_BITS-1:ANGLE_BITS-2];

    trs_mb_sinq #(.ANGLE_BITS(ANGLE_BITS)) u_sin (
      .clk_i (clk_i),
      .en_i  (en),
      .r_i   (rs[ax]),
      .s_o   (sin_a[ax])
    );

    trs_mb_sinq #(.ANGLE_BITS(ANGLE_BITS)) u_cos (
      .clk_i (clk_i),
      .en_i  (en),
      .r_i   (rc[ax]),
      .s_o   (sin_b[ax])
    );
  end

  assign meta_in.action = req_i.action;
  assign meta_in.pos    = {req_i.pos_z, req_i.pos_y, req_i.pos_x};
  assign meta_in.scale  = {req_i.scale_z, req_i.scale_y, req_i.scale_x};

  always_ff @(posedge clk_i) begin
    if (en) begin
      meta_q[0] <= meta_in;
      for (int k = 1; k < L - 1; k++) begin
        meta_q[k] <= meta_q[k-1];
      end
    end
  end

  always_comb begin
    for (int ax = 0; ax < AXES; ax++) begin
      unique case (meta_q[LS-1].quad[ax])
        QUAD_0: begin
          sv[ax] = ROT_W'(sin_a[ax]);
          cv[ax] = ROT_W'(sin_b[ax]);
        end
        QUAD_1: begin
          sv[ax] = ROT_W'(sin_b[ax]);
          cv[ax] = -ROT_W'(sin_a[ax]);
        end
        QUAD_2: begin
          sv[ax] = -ROT_W'(sin_a[ax]);
          cv[ax] = -ROT_W'(sin_b[ax]);
        end
        QUAD_3: begin
          sv[ax] = -ROT_W'(sin_b[ax]);
          cv[ax] = ROT_W'(sin_a[ax]);
        end
        default: begin
          sv[ax] = '0;
          cv[ax] = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      czsx_q <= rmul30(cv[2], sv[0]);
      cxcz_q <= rmul30(cv[0], cv[2]);
      sxsy_q <= rmul30(sv[0], sv[1]);
      cxsy_q <= rmul30(cv[0], sv[1]);
      cxsz_q <= rmul30(cv[0], sv[2]);
      sxsz_q <= rmul30(sv[0], sv[2]);
      r00_q  <= rmul30(cv[2], cv[1]);
      r10_q  <= rmul30(sv[2], cv[1]);
      r21_q  <= rmul30(sv[0], cv[1]);
      r22_q  <= rmul30(cv[0], cv[1]);
      sy_q   <= sv[1];
      sz_q   <= sv[2];

      t01_q   <= rmul30(czsx_q, sy_q);
      t02_q   <= rmul30(cxcz_q, sy_q);
      t11_q   <= rmul30(sxsy_q, sz_q);
      t12_q   <= rmul30(cxsy_q, sz_q);
      cxsz2_q <= cxsz_q;
      sxsz2_q <= sxsz_q;
      cxcz2_q <= cxcz_q;
      czsx2_q <= czsx_q;
      r00b_q  <= r00_q;
      r10b_q  <= r10_q;
      r20b_q  <= -sy_q;
      r21b_q  <= r21_q;
      r22b_q  <= r22_q;

      rot_q[0][0] <= r00b_q;
      rot_q[0][1] <= t01_q - cxsz2_q;
      rot_q[0][2] <= t02_q + sxsz2_q;
      rot_q[1][0] <= r10b_q;
      rot_q[1][1] <= t11_q + cxcz2_q;
      rot_q[1][2] <= t12_q - czsx2_q;
      rot_q[2][0] <= r20b_q;
      rot_q[2][1] <= r21b_q;
      rot_q[2][2] <= r22b_q;
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_row
    for (genvar j = 0; j < 3; j++) begin : g_col
      trs_mb_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .clk_i   (clk_i),
        .en_i    (en),
        .num_i   (rot_q[j][i]),
        .scale_i (meta_q[LS+2].scale[i]),
        .q_o     (minv[i][j])
      );
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        fwd_d[i][j] = sat32(64'(rmul30(ROT_W'(meta_q[LS+2].scale[j]), rot_q[i][j])));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      fwd_q[0] <= fwd_d;
      for (int k = 1; k <= LD; k++) begin
        fwd_q[k] <= fwd_q[k-1];
      end
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          minv_q[i][j] <= minv[i][j];
          tp_q[i][j]   <= rmulf(minv[i][j], $signed(meta_q[LS+LD+2].pos[j]));
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (meta_q[L-2].action == ACT_INV) begin
        for (int j = 0; j < 3; j++) begin
          mat_d[i*4+j] = minv_q[i][j];
        end
        mat_d[i*4+3] = sat32(-(tp_q[i][0] + tp_q[i][1] + tp_q[i][2]));
      end else begin
        for (int j = 0; j < 3; j++) begin
          mat_d[i*4+j] = fwd_q[LD][i][j];
        end
        mat_d[i*4+3] = meta_q[L-2].pos[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mat_q <= mat_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= mat_q;
    end
  end

  assign rsp_o.valid  = out_valid_q;
  assign rsp_o.m_r0c0 = out_q[0];
  assign rsp_o.m_r0c1 = out_q[1];
  assign rsp_o.m_r0c2 = out_q[2];
  assign rsp_o.m_r0c3 = out_q[3];
  assign rsp_o.m_r1c0 = out_q[4];
  assign rsp_o.m_r1c1 = out_q[5];
  assign rsp_o.m_r1c2 = out_q[6];
  assign rsp_o.m_r1c3 = out_q[7];
  assign rsp_o.m_r2c0 = out_q[8];
  assign rsp_o.m_r2c1 = out_q[9];
  assign rsp_o.m_r2c2 = out_q[10];
  assign rsp_o.m_r2c3 = out_q[11];

`ifndef ASSERT_OFF
  a_accept_enters : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> v_q[0])
    else $error("accepted beat did not enter the pipeline");

  a_load_shows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> out_valid_q)
    else $error("loaded result not presented");

  a_stall_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[L-1] && !en) |=> (v_q[L-1] && $stable(mat_q)))
    else $error("last stage changed while stalled");
`endif

endmodule

@@ tb/sv/tb_trs_matrix_builder_unit.sv @@
// Testbench of the TRS matrix builder: directed and random items checked against a predictor.
`timescale 1ns / 100ps

module tb_trs_matrix_builder_unit;
  import trs_mb_pkg::*;

  typedef struct packed {
    logic                          action;
    logic [AXES-1:0][POS_W-1:0]    pos;
    logic [AXES-1:0][ANG_W-1:0]    ang;
    logic [AXES-1:0][SCL_W-1:0]    scl;
  } xform_req_t;

  typedef logic [MAT_N-1:0][MAT_W-1:0] matrix_t;

  typedef struct {
    xform_req_t req;
    bit         typed;
    matrix_t    mat;
  } dir_row_t;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 150;
  localparam int RANDOM_ITEMS   = 1300;
  localparam logic [SCL_W-1:0] SCL_ONE = 24'h010000;

  logic clk;
  logic rst_n;

  trs_mb_in_if  req_if ();
  trs_mb_out_if rsp_if ();

  trs_matrix_builder_unit dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  matrix_t    matrix_q[$];
  int         mismatches;
  int         idle_cycles;
  int         stall_cycle;
  dir_row_t   dir_tab[$];

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic longint sat_q(input longint v);
    if (v > 64'sd2147483647) begin
      return 64'sd2147483647;
    end else if (v < -64'sd2147483648) begin
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic longint round_mul(input longint a, input longint b, input int sh);
    longint unsigned ma;
    longint unsigned mb;
    longint unsigned p;
    ma = (a < 0) ? -a : a;
    mb = (b < 0) ? -b : b;
    p  = (ma * mb + (64'd1 << (sh - 1))) >> sh;
    return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
  endfunction

  function automatic longint sine_quarter(input longint unsigned r);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned plus;
    longint unsigned minus;
    x     = (r * 64'd1686629713) >> 14;
    x2    = (x * x) >> 30;
    term  = x;
    plus  = x;
    minus = 64'd0;
    for (int k = 1; k <= 7; k++) begin
      term = ((term * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
      if (k % 2 == 1) begin
        minus += term;
      end else begin
        plus += term;
      end
    end
    if (minus >= plus) begin
      return 0;
    end
    if (plus - minus > (64'd1 << 30)) begin
      return longint'(64'd1 << 30);
    end
    return longint'(plus - minus);
  endfunction

  function automatic void sin_cos(input logic [ANG_W-1:0] ang, output longint s,
                                  output longint c);
    longint a;
    longint b;
    a = sine_quarter(64'(ang[13:0]));
    b = sine_quarter(64'd16384 - 64'(ang[13:0]));
    case (ang[15:14])
      QUAD_0: begin s = a;  c = b;  end
      QUAD_1: begin s = b;  c = -a; end
      QUAD_2: begin s = -a; c = -b; end
      default: begin s = -b; c = a; end
    endcase
  endfunction

  function automatic longint inv_scale_div(input longint num, input longint unsigned scl);
    longint unsigned n;
    longint unsigned q;
    if (scl == 0) begin
      if (num == 0) begin
        return 0;
      end
      return (num < 0) ? -64'sd2147483648 : 64'sd2147483647;
    end
    n = ((num < 0) ? -num : num) << 2;
    q = (n + scl / 2) / scl;
    return sat_q((num < 0) ? -longint'(q) : longint'(q));
  endfunction

  function automatic matrix_t build_matrix(input xform_req_t rq);
    longint  sx, cx, sy, cy, sz, cz;
    longint  rot[3][3];
    longint  m[3][4];
    longint  acc;
    matrix_t res;
    sin_cos(rq.ang[0], sx, cx);
    sin_cos(rq.ang[1], sy, cy);
    sin_cos(rq.ang[2], sz, cz);
    rot[0][0] = round_mul(cz, cy, 30);
    rot[0][1] = round_mul(round_mul(cz, sx, 30), sy, 30) - round_mul(cx, sz, 30);
    rot[0][2] = round_mul(round_mul(cx, cz, 30), sy, 30) + round_mul(sx, sz, 30);
    rot[1][0] = round_mul(sz, cy, 30);
    rot[1][1] = round_mul(round_mul(sx, sy, 30), sz, 30) + round_mul(cx, cz, 30);
    rot[1][2] = round_mul(round_mul(cx, sy, 30), sz, 30) - round_mul(cz, sx, 30);
    rot[2][0] = -sy;
    rot[2][1] = round_mul(sx, cy, 30);
    rot[2][2] = round_mul(cx, cy, 30);
    for (int i = 0; i < 3; i++) begin
      if (rq.action == ACT_FWD) begin
        for (int j = 0; j < 3; j++) begin
          m[i][j] = sat_q(round_mul(longint'(rq.scl[j]), rot[i][j], 30));
        end
        m[i][3] = longint'($signed(rq.pos[i]));
      end else begin
        acc = 0;
        for (int j = 0; j < 3; j++) begin
          m[i][j] = inv_scale_div(rot[j][i], 64'(rq.scl[i]));
        end
        for (int j = 0; j < 3; j++) begin
          acc += round_mul(m[i][j], longint'($signed(rq.pos[j])), FRAC_BITS_DEF);
        end
        m[i][3] = sat_q(-acc);
      end
      for (int j = 0; j < 4; j++) begin
        res[i * 4 + j] = m[i][j][31:0];
      end
    end
    return res;
  endfunction

  function automatic logic [ANG_W-1:0] rand_angle();
    logic [ANG_W-1:0] corners[8] = '{16'h0000, 16'h4000, 16'h8000, 16'hC000,
                                     16'hFFFF, 16'h0001, 16'h3FFF, 16'h7FFF};
    if ($urandom_range(3) == 0) begin
      return corners[$urandom_range(7)];
    end
    return ANG_W'($urandom);
  endfunction

  function automatic logic [SCL_W-1:0] rand_scale();
    case ($urandom_range(7))
      0: return '0;
      1: return SCL_ONE;
      2, 3: return SCL_W'($urandom);
      4: return SCL_W'(24'hFFFFFF - $urandom_range(3));
      default: return SCL_W'($urandom_range(24'h080000, 24'h002000));
    endcase
  endfunction

  function automatic xform_req_t rand_req();
    xform_req_t rq;
    rq.action = 1'($urandom);
    for (int a = 0; a < AXES; a++) begin
      rq.pos[a] = ($urandom_range(3) == 0) ? 32'($signed($urandom_range(200000)) - 100000)
                                           : 32'($urandom);
      rq.ang[a] = rand_angle();
      rq.scl[a] = rand_scale();
    end
    return rq;
  endfunction

  task automatic report_mismatch(input int idx, input logic [MAT_W-1:0] got,
                                 input logic [MAT_W-1:0] want);
    $display("mismatch m_r%0dc%0d: got %0d expected %0d", idx / 4, idx % 4,
             $signed(got), $signed(want));
    mismatches++;
  endtask

  task automatic load_directed();
    xform_req_t rq;
    matrix_t    m;
    rq = '0;
    rq.pos[0] = 32'sh7FFFFFFF;
    rq.pos[1] = 32'sh80000000;
    rq.pos[2] = 32'sh00012345;
    m = '0;
    m[3] = rq.pos[0];
    m[7] = rq.pos[1];
    m[11] = rq.pos[2];
    dir_tab.push_back('{rq, 1'b1, m});
    rq = '0;
    rq.action = ACT_INV;
    m = '0;
    m[0] = MAT_MAX;
    m[5] = MAT_MAX;
    m[10] = MAT_MAX;
    dir_tab.push_back('{rq, 1'b1, m});
    for (int r = 0; r < 20; r++) begin
      rq.action = r[0];
      for (int a = 0; a < AXES; a++) begin
        rq.ang[a] = ANG_W'((r / 2) * 16'h2000 + a * 16'h4000) - ANG_W'(r > 15);
        rq.scl[a] = (r % 5 == 0) ? 24'hFFFFFF : (r % 5 == 1) ? SCL_ONE
                  : (r % 5 == 2) ? 24'h000001 : (r % 5 == 3) ? 24'h000000 : 24'h018000;
        rq.pos[a] = (r % 3 == 0) ? 32'sh7FFFFFFF : (r % 3 == 1) ? 32'sh80000000
                  : 32'sh00010000;
      end
      dir_tab.push_back('{rq, 1'b0, '0});
    end
  endtask

  task automatic send_req(input xform_req_t rq, input bit typed, input matrix_t m,
                          inout int burst_left);
    int gap;
    req_if.valid   <= 1'b1;
    req_if.action  <= rq.action;
    req_if.pos_x   <= rq.pos[0];
    req_if.pos_y   <= rq.pos[1];
    req_if.pos_z   <= rq.pos[2];
    req_if.angle_x <= rq.ang[0];
    req_if.angle_y <= rq.ang[1];
    req_if.angle_z <= rq.ang[2];
    req_if.scale_x <= rq.scl[0];
    req_if.scale_y <= rq.scl[1];
    req_if.scale_z <= rq.scl[2];
    do begin
      @(posedge clk);
    end while (!req_if.ready);
    matrix_q.push_back(typed ? m : build_matrix(rq));
    burst_left--;
    if (burst_left <= 0) begin
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(12, 1);
      burst_left = $urandom_range(40, 1);
      if (gap > 0) begin
        req_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  always @(posedge clk) begin
    stall_cycle <= stall_cycle + 1;
    case ((stall_cycle / 300) % 3)
      0: rsp_if.ready <= 1'b1;
      1: rsp_if.ready <= ($urandom_range(1) == 0);
      default: rsp_if.ready <= ((stall_cycle % 23) < 15);
    endcase
  end

  always @(posedge clk) begin
    matrix_t got;
    matrix_t want;
    if (rsp_if.valid && rsp_if.ready) begin
      got = {rsp_if.m_r2c3, rsp_if.m_r2c2, rsp_if.m_r2c1, rsp_if.m_r2c0,
             rsp_if.m_r1c3, rsp_if.m_r1c2, rsp_if.m_r1c1, rsp_if.m_r1c0,
             rsp_if.m_r0c3, rsp_if.m_r0c2, rsp_if.m_r0c1, rsp_if.m_r0c0};
      if (matrix_q.size() == 0) begin
        $display("unexpected result beat");
        mismatches++;
      end else begin
        want = matrix_q.pop_front();
        for (int i = 0; i < MAT_N; i++) begin
          if (got[i] !== want[i]) begin
            report_mismatch(i, got[i], want[i]);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    int burst_left;
    mismatches     = 0;
    idle_cycles    = 0;
    stall_cycle    = 0;
    rst_n          = 1'b0;
    req_if.valid   = 1'b0;
    req_if.action  = ACT_FWD;
    req_if.pos_x   = '0;
    req_if.pos_y   = '0;
    req_if.pos_z   = '0;
    req_if.angle_x = '0;
    req_if.angle_y = '0;
    req_if.angle_z = '0;
    req_if.scale_x = '0;
    req_if.scale_y = '0;
    req_if.scale_z = '0;
    rsp_if.ready   = 1'b0;
    burst_left     = $urandom_range(40, 1);
    load_directed();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (dir_tab[k]) begin
      send_req(dir_tab[k].req, dir_tab[k].typed, dir_tab[k].mat, burst_left);
    end
    repeat (RANDOM_ITEMS) begin
      send_req(rand_req(), 1'b0, '0, burst_left);
    end
    req_if.valid <= 1'b0;
    while (matrix_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
